>>> rtl/core/amts_pkg.sv
// Package for the amplitude-modulated tone synthesiser core.
// Holds the microcode word types, the control program, the stream widths and
// the sine table function used at elaboration. It depends on nothing else.
package amts_pkg;

    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 24;
    localparam int SAMPLE_W   = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int AMPL_W     = 15;
    localparam int INDEX_W    = 16;
    localparam int COUNT_W    = 24;
    localparam int SINE_W     = 15;
    localparam int PC_W       = 3;
    localparam int ENV_W      = 32;
    localparam int PROD_W     = 64;
    localparam int ROUND_SH   = 45;

    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CARRIER_STEP = 3'd0,
        REG_CARRIER_AMPL = 3'd1,
        REG_MOD_STEP     = 3'd2,
        REG_MOD_INDEX    = 3'd3,
        REG_NUM_SAMPLES  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        TAB_NONE,
        TAB_MOD,
        TAB_CAR
    } t_tab_sel;

    typedef enum logic [1:0] {
        MUL_NONE,
        MUL_IDX_SIN,
        MUL_SIN_AMP,
        MUL_ENV_CAR
    } t_mul_sel;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } t_jump;

    typedef struct packed {
        t_tab_sel tab;
        t_mul_sel mul;
        logic     env_load;
        t_jump    jump;
    } t_uop;

    // Control program: read the modulator sine while waiting for a transfer,
    // then the carrier sine, three products on the shared multiplier, and a
    // final step that rounds, hands the sample over and advances the phases.
    function automatic t_uop ucode(input logic [PC_W-1:0] pc);
        t_uop u;
        u = '{tab: TAB_NONE, mul: MUL_NONE, env_load: 1'b0, jump: JMP_NEXT};
        unique case (pc)
            3'd0: u = '{tab: TAB_MOD,  mul: MUL_NONE,    env_load: 1'b0, jump: JMP_WAIT_IN};
            3'd1: u = '{tab: TAB_CAR,  mul: MUL_IDX_SIN, env_load: 1'b0, jump: JMP_NEXT};
            3'd2: u = '{tab: TAB_NONE, mul: MUL_SIN_AMP, env_load: 1'b1, jump: JMP_NEXT};
            3'd3: u = '{tab: TAB_NONE, mul: MUL_ENV_CAR, env_load: 1'b0, jump: JMP_NEXT};
            3'd4: u = '{tab: TAB_NONE, mul: MUL_NONE,    env_load: 1'b0, jump: JMP_WAIT_OUT};
            default: u = '{tab: TAB_NONE, mul: MUL_NONE, env_load: 1'b0, jump: JMP_WAIT_OUT};
        endcase
        return u;
    endfunction

    // Quarter-wave sine entry, unsigned Q0.15, from a Taylor series in Q30. Evaluated
    // only with constant arguments while the table is elaborated.
    function automatic logic [SINE_W-1:0] sine_q15(input int table_bits, input int i);
        logic [63:0] x;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        x = (HALF_PI_Q30 * 64'(i)) >> table_bits;
        term = x;
        sum = x;
        for (int k = 1; k <= 12; k++) begin
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
        end
        v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

>>> rtl/core/am_tone_synthesizer_core.sv
// Top level of the amplitude-modulated tone synthesiser.
// A microcoded sequencer drives a sine table, one shared multiplier and the
// phase accumulators. It depends on amts_pkg.

// Every accepted input transfer yields one output sample,
// (1 + mod_index * sin(modulator phase)) * carrier_ampl * sin(carrier phase),
// in signed Q4.12, with tlast on the final sample of each burst of num_samples.
// Before it reaches the output register, each sample takes one table read per sine and
// three products on the single shared
// multiplier, sequenced by a five-step control program whose first step waits
// for the input. The input is taken again in the cycle after the sample is
// written, so no new input is taken while a sample is still in progress;
// a stalled output holds the last step of the program. Setting bit 0
// of the input data clears both phases and the sample counter before that
// sample is made. Neither port is ready while reset is held. The configuration
// port is otherwise always ready; write it only while no sample is in progress.
module am_tone_synthesizer_core #(
    parameter int TABLE_BITS = 10,
    parameter int PHASE_BITS = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [amts_pkg::S_DATA_W-1:0]     i_s_tdata,   // [0] restart, rest zero
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [amts_pkg::M_DATA_W-1:0]     o_m_tdata,   // [16:0] sample, rest zero
    output logic                              o_m_tlast,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [amts_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [amts_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int QUARTER = 1 << TABLE_BITS;
    localparam int TIDX_W  = TABLE_BITS + 1;

    logic [amts_pkg::SINE_W-1:0] w_tab [QUARTER+1];

    for (genvar g = 0; g <= QUARTER; g++) begin : g_tab
        localparam logic [amts_pkg::SINE_W-1:0] Entry = amts_pkg::sine_q15(TABLE_BITS, g);
        assign w_tab[g] = Entry;
    end

    logic [PHASE_BITS-1:0]              r_car_step;
    logic [amts_pkg::AMPL_W-1:0]        r_car_ampl;
    logic [PHASE_BITS-1:0]              r_mod_step;
    logic signed [amts_pkg::INDEX_W-1:0] r_mod_index;
    logic [amts_pkg::COUNT_W-1:0]       r_num_samples;

    logic [PHASE_BITS-1:0]              r_car_ph;
    logic [PHASE_BITS-1:0]              r_mod_ph;
    logic [amts_pkg::COUNT_W-1:0]       r_count;
    logic [amts_pkg::PC_W-1:0]          r_pc;
    logic [amts_pkg::PC_W-1:0]          n_pc;

    logic [amts_pkg::SINE_W-1:0]        r_tab;
    logic signed [amts_pkg::ENV_W-1:0]  r_env;
    logic signed [amts_pkg::PROD_W-1:0] r_prod;

    logic                               r_out_valid;
    logic [amts_pkg::SAMPLE_W-1:0]      r_out_sample;
    logic                               r_out_last;

    amts_pkg::t_uop                     w_uop;
    logic                               w_in_xfer;
    logic                               w_out_free;
    logic                               w_finish;
    logic [PHASE_BITS-1:0]              w_tab_ph;
    logic [TABLE_BITS-1:0]              w_off;
    logic [TIDX_W-1:0]                  w_tidx;
    logic                               w_sin_neg;
    logic signed [amts_pkg::SINE_W:0]   w_sin;
    logic signed [31:0]                 w_mul_a;
    logic signed [31:0]                 w_mul_b;
    logic signed [amts_pkg::PROD_W-1:0] w_round;
    logic [amts_pkg::COUNT_W:0]         w_count_inc;
    logic                               w_last;

    assign w_uop      = amts_pkg::ucode(r_pc);
    assign o_s_tready = i_rst_n && (w_uop.jump == amts_pkg::JMP_WAIT_IN);
    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_finish   = (w_uop.jump == amts_pkg::JMP_WAIT_OUT) && w_out_free;
    assign o_cfg_ready = i_rst_n;

    always_comb begin
        n_pc = r_pc + 1'b1;
        unique case (w_uop.jump)
            amts_pkg::JMP_NEXT:     n_pc = r_pc + 1'b1;
            amts_pkg::JMP_WAIT_IN:  n_pc = w_in_xfer ? r_pc + 1'b1 : r_pc;
            amts_pkg::JMP_WAIT_OUT: n_pc = w_out_free ? '0 : r_pc;
            default:                n_pc = '0;
        endcase
    end

    always_comb begin
        if (w_uop.tab == amts_pkg::TAB_MOD) begin
            w_tab_ph = i_s_tdata[0] ? '0 : r_mod_ph;
        end else begin
            w_tab_ph = r_car_ph;
        end
        w_off  = w_tab_ph[PHASE_BITS-3 -: TABLE_BITS];
        w_tidx = w_tab_ph[PHASE_BITS-2] ? TIDX_W'(QUARTER) - {1'b0, w_off} : {1'b0, w_off};
    end

    always_comb begin
        w_sin_neg = (w_uop.mul == amts_pkg::MUL_IDX_SIN) ? r_mod_ph[PHASE_BITS-1]
                                                         : r_car_ph[PHASE_BITS-1];
        w_sin = w_sin_neg ? -$signed({1'b0, r_tab}) : $signed({1'b0, r_tab});
        unique case (w_uop.mul)
            amts_pkg::MUL_IDX_SIN: begin
                w_mul_a = 32'(r_mod_index);
                w_mul_b = 32'(w_sin);
            end
            amts_pkg::MUL_SIN_AMP: begin
                w_mul_a = 32'(w_sin);
                w_mul_b = $signed({17'd0, r_car_ampl});
            end
            amts_pkg::MUL_ENV_CAR: begin
                w_mul_a = r_env;
                w_mul_b = r_prod[31:0];
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_round = r_prod + (64'sd1 <<< (amts_pkg::ROUND_SH - 1))
                     - $signed({63'd0, r_prod[amts_pkg::PROD_W-1]});
    assign w_count_inc = {1'b0, r_count} + 1'b1;
    assign w_last = (w_count_inc >= {1'b0, r_num_samples});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_car_step    <= '0;
            r_car_ampl    <= '0;
            r_mod_step    <= '0;
            r_mod_index   <= '0;
            r_num_samples <= amts_pkg::COUNT_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                amts_pkg::REG_CARRIER_STEP: r_car_step    <= PHASE_BITS'(i_cfg_data);
                amts_pkg::REG_CARRIER_AMPL: r_car_ampl    <= i_cfg_data[amts_pkg::AMPL_W-1:0];
                amts_pkg::REG_MOD_STEP:     r_mod_step    <= PHASE_BITS'(i_cfg_data);
                amts_pkg::REG_MOD_INDEX:    r_mod_index   <= i_cfg_data[amts_pkg::INDEX_W-1:0];
                amts_pkg::REG_NUM_SAMPLES:  r_num_samples <= i_cfg_data[amts_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= '0;
            r_car_ph    <= '0;
            r_mod_ph    <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w_in_xfer && i_s_tdata[0]) begin
                r_car_ph <= '0;
                r_mod_ph <= '0;
                r_count  <= '0;
            end else if (w_finish) begin
                r_car_ph <= r_car_ph + r_car_step;
                r_mod_ph <= r_mod_ph + r_mod_step;
                r_count  <= w_last ? '0 : w_count_inc[amts_pkg::COUNT_W-1:0];
            end
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_uop.tab != amts_pkg::TAB_NONE) begin
            r_tab <= w_tab[w_tidx];
        end
        if (w_uop.env_load) begin
            r_env <= (32'sd1 <<< 27) + r_prod[31:0];
        end
        if (w_uop.mul != amts_pkg::MUL_NONE) begin
            r_prod <= w_mul_a * w_mul_b;
        end
        if (w_finish) begin
            r_out_sample <= w_round[amts_pkg::ROUND_SH +: amts_pkg::SAMPLE_W];
            r_out_last   <= w_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(amts_pkg::M_DATA_W - amts_pkg::SAMPLE_W){1'b0}}, r_out_sample};
    assign o_m_tlast  = r_out_last;

endmodule

>>> rtl/core/amts_checker.sv
// Port-level checks for the amplitude-modulated tone synthesiser core.
// Attached to am_tone_synthesizer_core by the bind below; uses amts_pkg widths.
module amts_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [amts_pkg::M_DATA_W-1:0]   o_m_tdata,
    input logic                            o_m_tlast
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
        else $error("Stalled output transfer changed.");

    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready ##1 !o_s_tready ##1 !o_s_tready ##1 !o_s_tready)
        else $error("Input taken again before the sample was finished.");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[amts_pkg::M_DATA_W-1:amts_pkg::SAMPLE_W] == '0))
        else $error("Output padding bits are not zero.");

endmodule

bind am_tone_synthesizer_core amts_checker u_amts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
